// ----- sv/brq_pkg.sv -----
`timescale 1ns / 1ps
// brq_pkg: sizes, operation and status codes, and shared structs for the
// broadcast ring queue. Depends on nothing.
package brq_pkg;

	localparam int DEPTH      = 16;
	localparam int CONSUMERS  = 8;
	localparam int DATA_WIDTH = 32;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CID_W = (CONSUMERS > 1) ? $clog2(CONSUMERS) : 1;
	localparam int CNT_W = $clog2(CONSUMERS + 1);

	// port field widths
	localparam int FUNC_W   = 2;
	localparam int ID_W     = 3;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 4;

	typedef enum logic [FUNC_W-1:0] {
		FN_SUBSCRIBE   = 2'd0,
		FN_UNSUBSCRIBE = 2'd1,
		FN_PRODUCE     = 2'd2,
		FN_CONSUME     = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK           = 3'd0,
		ST_NO_SLOT      = 3'd1,
		ST_FULL         = 3'd2,
		ST_NO_CONSUMERS = 3'd3,
		ST_EMPTY        = 3'd4,
		ST_INACTIVE     = 3'd5,
		ST_UNCOMMITTED  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_READ,
		FSM_HOLD
	} fsm_t;

	// store access from the index logic
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	// per-operation outcome, message word follows from the store
	typedef struct packed {
		status_t            status;
		logic [ID_W-1:0]    assigned_id;
		logic [COUNT_W-1:0] active_count;
		logic               msg_sel;
	} res_t;

endpackage

// ----- sv/brq_if.sv -----
`timescale 1ns / 1ps
// brq_in_if and brq_out_if: valid/ready channels for requests and results.
// Depends on brq_pkg for field widths.
interface brq_in_if;
	logic                           valid;
	logic                           ready;
	logic [brq_pkg::FUNC_W-1:0]     func;
	logic [brq_pkg::ID_W-1:0]       consumer_id;
	logic [brq_pkg::DATA_WIDTH-1:0] message_in;
	logic                           commit;

	modport source (output valid, func, consumer_id, message_in, commit, input ready);
	modport sink (input valid, func, consumer_id, message_in, commit, output ready);
endinterface

interface brq_out_if;
	logic                           valid;
	logic                           ready;
	logic [brq_pkg::STATUS_W-1:0]   status;
	logic [brq_pkg::ID_W-1:0]       assigned_id;
	logic [brq_pkg::DATA_WIDTH-1:0] message_out;
	logic [brq_pkg::COUNT_W-1:0]    active_count;

	modport source (output valid, status, assigned_id, message_out, active_count,
		input ready);
	modport sink (input valid, status, assigned_id, message_out, active_count,
		output ready);
endinterface

// ----- sv/brq_ram.sv -----
`timescale 1ns / 1ps
// brq_ram: generic simple dual-port RAM, one write and one registered read.
// Depends on nothing.
module brq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/brq_core.sv -----
`timescale 1ns / 1ps
// brq_core: consumer slots, read and write indices, and the decision for
// each operation, including store access. Depends on brq_pkg.
module brq_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [brq_pkg::FUNC_W-1:0]     func,
	input  logic [brq_pkg::ID_W-1:0]       consumer_id,
	input  logic                           commit,
	output brq_pkg::ram_req_t              ram_req,
	output brq_pkg::res_t                  res
);

	logic [brq_pkg::IDX_W-1:0] write_index_q;
	logic [brq_pkg::IDX_W-1:0] read_index_q [brq_pkg::CONSUMERS];
	logic [brq_pkg::CONSUMERS-1:0] active_q;
	logic [brq_pkg::CNT_W-1:0] total_q;

	logic [brq_pkg::CID_W-1:0] id_idx;
	logic                      id_ok;
	logic [brq_pkg::CID_W-1:0] free_slot;
	logic                      slot_found;
	logic [brq_pkg::IDX_W-1:0] wr_next;
	logic [brq_pkg::IDX_W-1:0] rd_cur;
	logic [brq_pkg::IDX_W-1:0] rd_next;
	logic                      full;

	logic                      set_active;
	logic                      clr_active;
	logic                      adv_write;
	logic                      adv_read;
	logic [brq_pkg::CNT_W-1:0] total_next;
	brq_pkg::status_t          status;

	function automatic logic [brq_pkg::IDX_W-1:0] ring_next(
		input logic [brq_pkg::IDX_W-1:0] idx
	);
		return (idx == brq_pkg::IDX_W'(brq_pkg::DEPTH - 1)) ? '0 : idx + 1'b1;
	endfunction

	// id decode
	assign id_idx  = brq_pkg::CID_W'(consumer_id);
	assign id_ok   = (32'(consumer_id) < 32'(brq_pkg::CONSUMERS)) && active_q[id_idx];
	assign wr_next = ring_next(write_index_q);
	assign rd_cur  = read_index_q[id_idx];
	assign rd_next = ring_next(rd_cur);

	// lowest free slot
	always_comb begin
		free_slot  = '0;
		slot_found = 1'b0;
		for (int i = brq_pkg::CONSUMERS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_slot  = brq_pkg::CID_W'(i);
				slot_found = 1'b1;
			end
		end
	end

	// full when any active reader sits on the next write slot
	always_comb begin
		full = 1'b0;
		for (int i = 0; i < brq_pkg::CONSUMERS; i++) begin
			if (active_q[i] && (read_index_q[i] == wr_next)) begin
				full = 1'b1;
			end
		end
	end

	// operation decision
	always_comb begin
		status     = brq_pkg::ST_OK;
		set_active = 1'b0;
		clr_active = 1'b0;
		adv_write  = 1'b0;
		adv_read   = 1'b0;
		ram_req    = '0;
		unique case (brq_pkg::func_t'(func))
			brq_pkg::FN_SUBSCRIBE: begin
				if (!slot_found) begin
					status = brq_pkg::ST_NO_SLOT;
				end else begin
					set_active = 1'b1;
				end
			end
			brq_pkg::FN_UNSUBSCRIBE: begin
				if (!id_ok) begin
					status = brq_pkg::ST_INACTIVE;
				end else begin
					clr_active = 1'b1;
				end
			end
			brq_pkg::FN_PRODUCE: begin
				if (total_q == '0) begin
					status = brq_pkg::ST_NO_CONSUMERS;
				end else if (full) begin
					status = brq_pkg::ST_FULL;
				end else begin
					ram_req.we    = 1'b1;
					ram_req.waddr = wr_next;
					if (commit) begin
						adv_write = 1'b1;
					end else begin
						status = brq_pkg::ST_UNCOMMITTED;
					end
				end
			end
			brq_pkg::FN_CONSUME: begin
				if (!id_ok) begin
					status = brq_pkg::ST_INACTIVE;
				end else if (rd_cur == write_index_q) begin
					status = brq_pkg::ST_EMPTY;
				end else begin
					ram_req.re    = 1'b1;
					ram_req.raddr = rd_next;
					if (commit) begin
						adv_read = 1'b1;
					end else begin
						status = brq_pkg::ST_UNCOMMITTED;
					end
				end
			end
			default: begin
				status = brq_pkg::ST_OK;
			end
		endcase
		ram_req.we = ram_req.we & fire;
		ram_req.re = ram_req.re & fire;
	end

	// count after this operation
	always_comb begin
		total_next = total_q;
		if (set_active) begin
			total_next = total_q + 1'b1;
		end else if (clr_active) begin
			total_next = total_q - 1'b1;
		end
	end

	assign res.status       = status;
	assign res.assigned_id  = set_active ? brq_pkg::ID_W'(free_slot) : '0;
	assign res.active_count = brq_pkg::COUNT_W'(total_next);
	assign res.msg_sel      = ram_req.re;

	// slot and index state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			active_q      <= '0;
			total_q       <= '0;
			for (int i = 0; i < brq_pkg::CONSUMERS; i++) begin
				read_index_q[i] <= '0;
			end
		end else if (fire) begin
			total_q <= total_next;
			if (adv_write) begin
				write_index_q <= wr_next;
			end
			if (set_active) begin
				active_q[free_slot]     <= 1'b1;
				read_index_q[free_slot] <= write_index_q;
			end
			if (clr_active) begin
				active_q[id_idx] <= 1'b0;
			end
			if (adv_read) begin
				read_index_q[id_idx] <= rd_next;
			end
		end
	end

endmodule

// ----- sv/broadcast_ring_queue.sv -----
`timescale 1ns / 1ps
// broadcast_ring_queue: top level with request/result sequencing, the
// message store and the output register. Depends on brq_pkg, brq_if,
// brq_ram and brq_core.

// One producer and up to CONSUMERS independent readers share a ring of DEPTH
// message words. Each request is one operation (subscribe, unsubscribe,
// produce, consume) and gives exactly one result. Slot and index state is
// decided and updated at acceptance, the message store (one registered-read
// RAM) returns the word in the next cycle, and the result register then holds
// the result until it is taken. A new request is accepted once the previous
// result has been taken. Nothing is swept after reset; the block is ready as
// soon as reset is released.
module broadcast_ring_queue (
	input  logic       clk,
	input  logic       arst_n,
	brq_in_if.sink     req,
	brq_out_if.source  rsp
);

	brq_pkg::fsm_t     state_q;
	brq_pkg::fsm_t     state_next;
	logic              fire;
	logic              capture_msg;
	brq_pkg::ram_req_t ram_req;
	brq_pkg::res_t     res;
	brq_pkg::res_t     res_s1;
	logic [brq_pkg::DATA_WIDTH-1:0] rdata;
	logic [brq_pkg::DATA_WIDTH-1:0] msg_q;

	assign fire = req.valid && req.ready;

	brq_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.func        (req.func),
		.consumer_id (req.consumer_id),
		.commit      (req.commit),
		.ram_req     (ram_req),
		.res         (res)
	);

	brq_ram #(
		.WIDTH (brq_pkg::DATA_WIDTH),
		.DEPTH (brq_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (req.message_in),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			brq_pkg::FSM_IDLE: begin
				if (req.valid) begin
					state_next = brq_pkg::FSM_READ;
				end
			end
			brq_pkg::FSM_READ: begin
				state_next = brq_pkg::FSM_HOLD;
			end
			brq_pkg::FSM_HOLD: begin
				if (rsp.ready) begin
					state_next = brq_pkg::FSM_IDLE;
				end
			end
			default: begin
				state_next = brq_pkg::FSM_IDLE;
			end
		endcase
	end

	// handshake outputs
	always_comb begin
		req.ready   = 1'b0;
		rsp.valid   = 1'b0;
		capture_msg = 1'b0;
		unique case (state_q)
			brq_pkg::FSM_IDLE: req.ready   = 1'b1;
			brq_pkg::FSM_READ: capture_msg = 1'b1;
			brq_pkg::FSM_HOLD: rsp.valid   = 1'b1;
			default: req.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brq_pkg::FSM_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			res_s1 <= res;
		end
		if (capture_msg) begin
			msg_q <= res_s1.msg_sel ? rdata : '0;
		end
	end

	assign rsp.status       = res_s1.status;
	assign rsp.assigned_id  = res_s1.assigned_id;
	assign rsp.active_count = res_s1.active_count;
	assign rsp.message_out  = msg_q;

`ifndef SYNTH
	// requests and results never overlap
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !rsp.valid)
		else $error("request ready while a result is pending");

	// every accepted request passes through the read state and then shows its result
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |-> ##2 rsp.valid)
		else $error("result not presented after request");

	// message word is zero unless a consume read the store
	a_msg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != brq_pkg::ST_OK
			&& rsp.status != brq_pkg::ST_UNCOMMITTED) |-> (rsp.message_out == '0))
		else $error("message returned on a failed operation");

	// a result stays until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.message_out)))
		else $error("result dropped while stalled");
`endif

endmodule
